FILE: design/cbrs_pkg.sv
package cbrs_pkg;

  // field widths fixed by the event and result formats
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ERRCNT_W = 9;
  localparam int unsigned CFG_W    = 24;

  // configuration register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = '0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd16;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;

  // event kinds
  localparam logic [1:0] CMD_POLL      = 2'd0;
  localparam logic [1:0] CMD_TX        = 2'd1;
  localparam logic [1:0] CMD_INSTALL   = 2'd2;
  localparam logic [1:0] CMD_UNINSTALL = 2'd3;

  // controller states
  localparam logic [1:0] CTRL_STOPPED    = 2'd0;
  localparam logic [1:0] CTRL_RUNNING    = 2'd1;
  localparam logic [1:0] CTRL_BUSOFF     = 2'd2;
  localparam logic [1:0] CTRL_RECOVERING = 2'd3;

  // transmit outcomes
  localparam logic [1:0] TX_SENT    = 2'd0;
  localparam logic [1:0] TX_TIMEOUT = 2'd1;

  // error levels and their thresholds
  localparam logic [1:0] LVL_ACTIVE  = 2'd0;
  localparam logic [1:0] LVL_WARNING = 2'd1;
  localparam logic [1:0] LVL_PASSIVE = 2'd2;
  localparam logic [1:0] LVL_BUSOFF  = 2'd3;

  localparam logic [ERRCNT_W:0] WARN_COUNT    = 10'd96;
  localparam logic [ERRCNT_W:0] PASSIVE_COUNT = 10'd128;
  localparam logic [ERRCNT_W:0] BUSOFF_COUNT  = 10'd256;

  typedef enum logic [2:0] {
    MODE_DISABLED   = 3'd0,
    MODE_STOPPED    = 3'd1,
    MODE_PROBING    = 3'd2,
    MODE_RUNNING    = 3'd3,
    MODE_BUSOFF     = 3'd4,
    MODE_RECOVERING = 3'd5,
    MODE_ERROR      = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_PROBE     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_RECOVER   = 3'd3,
    ACT_REINSTALL = 3'd4,
    ACT_RESTART   = 3'd5,
    ACT_UNINSTALL = 3'd6
  } action_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [NOW_W-1:0]    now_ms;
    logic                status_ok;
    logic [1:0]          ctrl_state;
    logic [ERRCNT_W-1:0] tx_error_count;
    logic [ERRCNT_W-1:0] rx_error_count;
    logic [1:0]          tx_outcome;
    logic                install_ok;
  } evt_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         error_level;
    logic [2:0]         action;
    logic               tx_accepted;
    logic [COUNT_W-1:0] timeout_count;
  } res_t;

  // requests from the mode logic to the recovery timer
  typedef struct packed {
    logic arm;
    logic clear;
  } timer_ctl_t;

endpackage

FILE: design/cbrs_channels.sv
interface cbrs_evt_if;
  logic            valid;
  logic            ready;
  cbrs_pkg::evt_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbrs_res_if;
  logic            valid;
  logic            ready;
  cbrs_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/can_bus_off_recovery_supervisor.sv
// channel  dir  payload                                          handshake
// evt      in   cmd, now_ms, status, ctrl state, error counts    valid/ready
// res      out  mode, error_level, action, tx_accepted, count    valid/ready
// cfg      in   cfg_index selects period or timeout limit        cfg_write only
//
// one event per cycle sustained while res drains; an evt beat reaches res through
// (input register, then mode logic and recovery timer into the result register)
// sync reset clears both registers' valid flags, mode, timeouts and timer
// a stalled res keeps its beat; evt still fills an empty input register
module can_bus_off_recovery_supervisor #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [cbrs_pkg::CFG_W-1:0]    cfg_data,
  cbrs_evt_if.sink                      evt,
  cbrs_res_if.source                    res
);

  logic                              evt_valid_q;
  cbrs_pkg::evt_t                    evt_q;
  logic                              res_valid;
  cbrs_pkg::res_t                    res_q;
  logic                              advance;

  logic [cbrs_pkg::PERIOD_W-1:0]     period;
  logic [cbrs_pkg::LIMIT_W-1:0]      limit;

  cbrs_pkg::mode_t                   mode;
  cbrs_pkg::mode_t                   mode_next;
  logic [cbrs_pkg::COUNT_W-1:0]      timeouts;
  logic [cbrs_pkg::COUNT_W-1:0]      timeouts_next;
  logic [TIME_BITS-1:0]              deadline;
  logic                              armed;

  logic [TIME_BITS-1:0]              now_t;
  logic [TIME_BITS-1:0]              since;
  logic                              due;
  cbrs_pkg::timer_ctl_t              tmr;
  cbrs_pkg::res_t                    step_res;

  // handshake: the stage moves when the result register is free or being drained
  assign advance   = evt_valid_q && (!res_valid || res.ready);
  assign evt.ready = !evt_valid_q || advance;
  assign res.valid = res_valid;
  assign res.data  = res_q;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid_q <= 1'b0;
    end else if (evt.ready) begin
      evt_valid_q <= evt.valid;
    end
    if (evt.ready && evt.valid) begin
      evt_q <= evt.data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= cbrs_pkg::PERIOD_RESET;
      limit  <= cbrs_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cbrs_pkg::REG_PERIOD: period <= cfg_data[cbrs_pkg::PERIOD_W-1:0];
        cbrs_pkg::REG_LIMIT:  limit  <= cfg_data[cbrs_pkg::LIMIT_W-1:0];
        default:              limit  <= limit;
      endcase
    end
  end

  // recovery timer: expired once now has reached the deadline modulo the time width
  assign now_t = TIME_BITS'(evt_q.now_ms);
  assign since = now_t - deadline;
  assign due   = armed && (period != '0) && !since[TIME_BITS-1];

  cbrs_step u_step (
    .evt           (evt_q),
    .mode          (mode),
    .timeouts      (timeouts),
    .limit         (limit),
    .due           (due),
    .mode_next     (mode_next),
    .timeouts_next (timeouts_next),
    .tmr           (tmr),
    .res           (step_res)
  );

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= cbrs_pkg::MODE_DISABLED;
      timeouts <= '0;
      armed    <= 1'b0;
      deadline <= '0;
    end else if (advance) begin
      mode     <= mode_next;
      timeouts <= timeouts_next;
      if (tmr.arm) begin
        armed    <= (period != '0);
        deadline <= now_t + TIME_BITS'(period);
      end else if (tmr.clear) begin
        armed <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

endmodule

FILE: design/cbrs_step.sv
module cbrs_step (
  input  cbrs_pkg::evt_t                  evt,
  input  cbrs_pkg::mode_t                 mode,
  input  logic [cbrs_pkg::COUNT_W-1:0]    timeouts,
  input  logic [cbrs_pkg::LIMIT_W-1:0]    limit,
  input  logic                            due,
  output cbrs_pkg::mode_t                 mode_next,
  output logic [cbrs_pkg::COUNT_W-1:0]    timeouts_next,
  output cbrs_pkg::timer_ctl_t            tmr,
  output cbrs_pkg::res_t                  res
);

  logic [1:0]                 graded;
  logic [1:0]                 level;
  cbrs_pkg::action_t          act;
  logic                       accepted;
  logic [cbrs_pkg::ERRCNT_W:0] tec;
  logic [cbrs_pkg::ERRCNT_W:0] rec;

  // grade error counters
  always_comb begin
    tec = {1'b0, evt.tx_error_count};
    rec = {1'b0, evt.rx_error_count};
    if (tec < cbrs_pkg::WARN_COUNT && rec < cbrs_pkg::WARN_COUNT) begin
      graded = cbrs_pkg::LVL_ACTIVE;
    end else if (tec < cbrs_pkg::PASSIVE_COUNT && rec < cbrs_pkg::PASSIVE_COUNT) begin
      graded = cbrs_pkg::LVL_WARNING;
    end else if (tec < cbrs_pkg::BUSOFF_COUNT && rec < cbrs_pkg::BUSOFF_COUNT) begin
      graded = cbrs_pkg::LVL_PASSIVE;
    end else begin
      graded = cbrs_pkg::LVL_BUSOFF;
    end
  end

  // mode transitions per event
  always_comb begin
    mode_next     = mode;
    timeouts_next = timeouts;
    tmr           = '0;
    level         = cbrs_pkg::LVL_ACTIVE;
    act           = cbrs_pkg::ACT_NONE;
    accepted      = 1'b0;
    case (evt.cmd)
      cbrs_pkg::CMD_POLL: begin
        if (mode == cbrs_pkg::MODE_DISABLED) begin
          mode_next = mode;
        end else if (!evt.status_ok || mode == cbrs_pkg::MODE_ERROR) begin
          mode_next = cbrs_pkg::MODE_DISABLED;
        end else begin
          level = graded;
          // follow the controller's own state first
          if (evt.ctrl_state == cbrs_pkg::CTRL_STOPPED
              && mode != cbrs_pkg::MODE_STOPPED) begin
            mode_next = cbrs_pkg::MODE_STOPPED;
          end else if (evt.ctrl_state == cbrs_pkg::CTRL_BUSOFF
                       && mode != cbrs_pkg::MODE_BUSOFF) begin
            tmr.arm   = 1'b1;
            mode_next = cbrs_pkg::MODE_BUSOFF;
          end else if (evt.ctrl_state == cbrs_pkg::CTRL_RECOVERING
                       && mode != cbrs_pkg::MODE_RECOVERING) begin
            mode_next = cbrs_pkg::MODE_RECOVERING;
          end else begin
            case (mode)
              cbrs_pkg::MODE_STOPPED: begin
                tmr.arm = 1'b1;
                if (evt.ctrl_state == cbrs_pkg::CTRL_RUNNING) begin
                  mode_next = cbrs_pkg::MODE_RUNNING;
                end else begin
                  act       = cbrs_pkg::ACT_PROBE;
                  mode_next = cbrs_pkg::MODE_PROBING;
                end
              end
              cbrs_pkg::MODE_PROBING: begin
                if (due) begin
                  tmr.clear = 1'b1;
                  if (evt.tx_error_count == '0) begin
                    act       = cbrs_pkg::ACT_RESTART;
                    mode_next = cbrs_pkg::MODE_RUNNING;
                  end else begin
                    act       = cbrs_pkg::ACT_STOP;
                    mode_next = cbrs_pkg::MODE_STOPPED;
                  end
                end
              end
              cbrs_pkg::MODE_RUNNING: begin
                // of the error levels only passive stops; bus-off is left to the controller
                if (due) begin
                  if (graded == cbrs_pkg::LVL_PASSIVE) begin
                    act       = cbrs_pkg::ACT_STOP;
                    mode_next = cbrs_pkg::MODE_STOPPED;
                  end else if (timeouts >= limit) begin
                    act           = cbrs_pkg::ACT_REINSTALL;
                    timeouts_next = '0;
                    mode_next     = cbrs_pkg::MODE_STOPPED;
                  end
                end
              end
              cbrs_pkg::MODE_BUSOFF: begin
                if (due) begin
                  act       = cbrs_pkg::ACT_RECOVER;
                  mode_next = cbrs_pkg::MODE_RECOVERING;
                end
              end
              cbrs_pkg::MODE_RECOVERING: begin
                mode_next = mode;
              end
              default: begin
                mode_next = cbrs_pkg::MODE_ERROR;
              end
            endcase
          end
        end
      end
      cbrs_pkg::CMD_TX: begin
        if (mode == cbrs_pkg::MODE_RUNNING) begin
          accepted = 1'b1;
          if (evt.tx_outcome == cbrs_pkg::TX_SENT) begin
            timeouts_next = '0;
          end else if (evt.tx_outcome == cbrs_pkg::TX_TIMEOUT
                       && timeouts != cbrs_pkg::COUNT_MAX) begin
            timeouts_next = timeouts + 1'b1;
          end
        end
      end
      cbrs_pkg::CMD_INSTALL: begin
        if (evt.install_ok) begin
          timeouts_next = '0;
          mode_next     = cbrs_pkg::MODE_STOPPED;
        end else begin
          mode_next = cbrs_pkg::MODE_DISABLED;
        end
      end
      default: begin
        act       = cbrs_pkg::ACT_UNINSTALL;
        mode_next = cbrs_pkg::MODE_DISABLED;
      end
    endcase
  end

  // result beat
  assign res.mode          = mode_next;
  assign res.error_level   = level;
  assign res.action        = act;
  assign res.tx_accepted   = accepted;
  assign res.timeout_count = timeouts_next;

endmodule

FILE: design/cbrs_checker.sv
module cbrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input cbrs_pkg::res_t res_data
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a stalled beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result beat changed");

  // uninstall always lands in disabled
  a_uninstall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.action == cbrs_pkg::ACT_UNINSTALL
    |-> res_data.mode == cbrs_pkg::MODE_DISABLED)
    else $error("uninstall without disabled mode");

  // an accepted transmit only happens in running mode, with no action or grade
  a_tx_running: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.tx_accepted
    |-> res_data.mode == cbrs_pkg::MODE_RUNNING
        && res_data.action == cbrs_pkg::ACT_NONE
        && res_data.error_level == cbrs_pkg::LVL_ACTIVE)
    else $error("transmit accepted outside running mode");

  // reinstall clears the timeout count and stops
  a_reinstall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.action == cbrs_pkg::ACT_REINSTALL
    |-> res_data.timeout_count == '0 && res_data.mode == cbrs_pkg::MODE_STOPPED)
    else $error("reinstall left count or mode");

endmodule

bind can_bus_off_recovery_supervisor cbrs_checker u_cbrs_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LATENCY = 2;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_write;
  logic                       cfg_index;
  logic [cbrs_pkg::CFG_W-1:0] cfg_data;

  cbrs_evt_if evt_bus ();
  cbrs_res_if res_bus ();

  can_bus_off_recovery_supervisor DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_bus),
    .res       (res_bus)
  );

  always #5 clk = ~clk;

  // shadow copy of the supervisor state and its registers
  cbrs_pkg::mode_t                sup_mode;
  logic [cbrs_pkg::NOW_W-1:0]     sup_deadline;
  logic                           sup_armed;
  logic [cbrs_pkg::COUNT_W-1:0]   sup_timeouts;
  logic [cbrs_pkg::PERIOD_W-1:0]  cfg_period;
  logic [cbrs_pkg::LIMIT_W-1:0]   cfg_limit;

  cbrs_pkg::res_t                 pending_results[$];
  cbrs_pkg::res_t                 oldest_result;
  int unsigned                    mismatches = 0;
  logic                           last_was_noop;
  logic                           steady = 1'b0;
  int unsigned                    hold_cycles = 0;
  logic [cbrs_pkg::NOW_W-1:0]     clock_ms = '0;

  // error level from the two controller counters
  function automatic logic [1:0] grade_counts(logic [cbrs_pkg::ERRCNT_W-1:0] tec,
                                              logic [cbrs_pkg::ERRCNT_W-1:0] rec);
    logic [cbrs_pkg::ERRCNT_W:0] t;
    logic [cbrs_pkg::ERRCNT_W:0] r;
    t = {1'b0, tec};
    r = {1'b0, rec};
    if (t < cbrs_pkg::WARN_COUNT && r < cbrs_pkg::WARN_COUNT)
      return cbrs_pkg::LVL_ACTIVE;
    if (t < cbrs_pkg::PASSIVE_COUNT && r < cbrs_pkg::PASSIVE_COUNT)
      return cbrs_pkg::LVL_WARNING;
    if (t < cbrs_pkg::BUSOFF_COUNT && r < cbrs_pkg::BUSOFF_COUNT)
      return cbrs_pkg::LVL_PASSIVE;
    return cbrs_pkg::LVL_BUSOFF;
  endfunction

  function automatic void arm_recovery(logic [cbrs_pkg::NOW_W-1:0] now);
    sup_armed    = (cfg_period != '0);
    sup_deadline = now + {{(cbrs_pkg::NOW_W - cbrs_pkg::PERIOD_W){1'b0}}, cfg_period};
  endfunction

  // next result of the supervisor for one event, updating the shadow state
  function automatic cbrs_pkg::res_t supervise_event(cbrs_pkg::evt_t e);
    cbrs_pkg::res_t             r;
    logic [1:0]                 lvl;
    cbrs_pkg::action_t          act;
    logic                       acc;
    logic                       due;
    logic [cbrs_pkg::NOW_W-1:0] diff;
    lvl = cbrs_pkg::LVL_ACTIVE;
    act = cbrs_pkg::ACT_NONE;
    acc = 1'b0;
    last_was_noop = (e.cmd == cbrs_pkg::CMD_POLL && sup_mode == cbrs_pkg::MODE_DISABLED) ||
                    (e.cmd == cbrs_pkg::CMD_TX && sup_mode != cbrs_pkg::MODE_RUNNING);
    case (e.cmd)
      cbrs_pkg::CMD_POLL: begin
        if (sup_mode == cbrs_pkg::MODE_DISABLED) begin
        end else if (!e.status_ok || sup_mode == cbrs_pkg::MODE_ERROR) begin
          sup_mode = cbrs_pkg::MODE_DISABLED;
        end else begin
          diff = e.now_ms - sup_deadline;
          due  = (cfg_period != '0) && sup_armed && !diff[cbrs_pkg::NOW_W-1];
          lvl  = grade_counts(e.tx_error_count, e.rx_error_count);
          if (e.ctrl_state == cbrs_pkg::CTRL_STOPPED
              && sup_mode != cbrs_pkg::MODE_STOPPED) begin
            sup_mode = cbrs_pkg::MODE_STOPPED;
          end else if (e.ctrl_state == cbrs_pkg::CTRL_BUSOFF
                       && sup_mode != cbrs_pkg::MODE_BUSOFF) begin
            arm_recovery(e.now_ms);
            sup_mode = cbrs_pkg::MODE_BUSOFF;
          end else if (e.ctrl_state == cbrs_pkg::CTRL_RECOVERING
                       && sup_mode != cbrs_pkg::MODE_RECOVERING) begin
            sup_mode = cbrs_pkg::MODE_RECOVERING;
          end else begin
            case (sup_mode)
              cbrs_pkg::MODE_STOPPED: begin
                if (e.ctrl_state == cbrs_pkg::CTRL_RUNNING) begin
                  sup_mode = cbrs_pkg::MODE_RUNNING;
                end else begin
                  act      = cbrs_pkg::ACT_PROBE;
                  sup_mode = cbrs_pkg::MODE_PROBING;
                end
                arm_recovery(e.now_ms);
              end
              cbrs_pkg::MODE_PROBING: begin
                if (due) begin
                  sup_armed = 1'b0;
                  if (e.tx_error_count == '0) begin
                    act      = cbrs_pkg::ACT_RESTART;
                    sup_mode = cbrs_pkg::MODE_RUNNING;
                  end else begin
                    act      = cbrs_pkg::ACT_STOP;
                    sup_mode = cbrs_pkg::MODE_STOPPED;
                  end
                end
              end
              cbrs_pkg::MODE_RUNNING: begin
                if (due) begin
                  if (lvl == cbrs_pkg::LVL_PASSIVE) begin
                    act      = cbrs_pkg::ACT_STOP;
                    sup_mode = cbrs_pkg::MODE_STOPPED;
                  end else if (sup_timeouts >= cfg_limit) begin
                    act          = cbrs_pkg::ACT_REINSTALL;
                    sup_timeouts = '0;
                    sup_mode     = cbrs_pkg::MODE_STOPPED;
                  end
                end
              end
              cbrs_pkg::MODE_BUSOFF: begin
                if (due) begin
                  act      = cbrs_pkg::ACT_RECOVER;
                  sup_mode = cbrs_pkg::MODE_RECOVERING;
                end
              end
              cbrs_pkg::MODE_RECOVERING: begin
              end
              default: sup_mode = cbrs_pkg::MODE_ERROR;
            endcase
          end
        end
      end
      cbrs_pkg::CMD_TX: begin
        if (sup_mode == cbrs_pkg::MODE_RUNNING) begin
          acc = 1'b1;
          if (e.tx_outcome == cbrs_pkg::TX_SENT) sup_timeouts = '0;
          else if (e.tx_outcome == cbrs_pkg::TX_TIMEOUT && sup_timeouts < cbrs_pkg::COUNT_MAX)
            sup_timeouts = sup_timeouts + 1'b1;
        end
      end
      cbrs_pkg::CMD_INSTALL: begin
        if (e.install_ok) begin
          sup_timeouts = '0;
          sup_mode     = cbrs_pkg::MODE_STOPPED;
        end else begin
          sup_mode = cbrs_pkg::MODE_DISABLED;
        end
      end
      default: begin
        act      = cbrs_pkg::ACT_UNINSTALL;
        sup_mode = cbrs_pkg::MODE_DISABLED;
      end
    endcase
    r.mode          = sup_mode;
    r.error_level   = lvl;
    r.action        = act;
    r.tx_accepted   = acc;
    r.timeout_count = sup_timeouts;
    return r;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // result checker: every res beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report("result beat with no event pending");
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_bus.data.mode !== oldest_result.mode)
          report($sformatf("mode %0d, expected %0d",
                           res_bus.data.mode, oldest_result.mode));
        if (res_bus.data.error_level !== oldest_result.error_level)
          report($sformatf("error_level %0d, expected %0d",
                           res_bus.data.error_level, oldest_result.error_level));
        if (res_bus.data.action !== oldest_result.action)
          report($sformatf("action %0d, expected %0d",
                           res_bus.data.action, oldest_result.action));
        if (res_bus.data.tx_accepted !== oldest_result.tx_accepted)
          report($sformatf("tx_accepted %0d, expected %0d",
                           res_bus.data.tx_accepted, oldest_result.tx_accepted));
        if (res_bus.data.timeout_count !== oldest_result.timeout_count)
          report($sformatf("timeout_count %0d, expected %0d",
                           res_bus.data.timeout_count, oldest_result.timeout_count));
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    logic hold_done;
    hold_done     = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0 && !hold_done) begin
        hold_done = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
      end
      res_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 6);
    end
  end

  // one event beat; called and returns at a falling edge
  task automatic send_event(input cbrs_pkg::evt_t e);
    while (!steady && $urandom_range(0, 99) < 6) begin
      evt_bus.valid <= 1'b0;
      @(negedge clk);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.data  <= e;
    do @(posedge clk); while (evt_bus.ready !== 1'b1);
    pending_results.push_back(supervise_event(e));
    @(negedge clk);
  endtask

  task automatic send_poll(input logic [cbrs_pkg::NOW_W-1:0] now, input logic ok,
                           input logic [1:0] ctrl,
                           input logic [cbrs_pkg::ERRCNT_W-1:0] tec,
                           input logic [cbrs_pkg::ERRCNT_W-1:0] rec);
    cbrs_pkg::evt_t e;
    e = '0;
    e.cmd            = cbrs_pkg::CMD_POLL;
    e.now_ms         = now;
    e.status_ok      = ok;
    e.ctrl_state     = ctrl;
    e.tx_error_count = tec;
    e.rx_error_count = rec;
    clock_ms = now;
    send_event(e);
  endtask

  task automatic send_tx(input logic [1:0] outcome);
    cbrs_pkg::evt_t e;
    e = '0;
    e.cmd        = cbrs_pkg::CMD_TX;
    e.now_ms     = clock_ms;
    e.tx_outcome = outcome;
    send_event(e);
  endtask

  task automatic send_install(input logic ok);
    cbrs_pkg::evt_t e;
    e = '0;
    e.cmd        = cbrs_pkg::CMD_INSTALL;
    e.now_ms     = clock_ms;
    e.install_ok = ok;
    send_event(e);
  endtask

  task automatic send_uninstall();
    cbrs_pkg::evt_t e;
    e = '0;
    e.cmd    = cbrs_pkg::CMD_UNINSTALL;
    e.now_ms = clock_ms;
    send_event(e);
  endtask

  // stop offering and let every expected result come back
  task automatic wait_for_results();
    evt_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // both registers, only while the block is idle
  task automatic set_registers(input logic [cbrs_pkg::PERIOD_W-1:0] period,
                               input logic [cbrs_pkg::LIMIT_W-1:0] limit);
    cfg_write  <= 1'b1;
    cfg_index  <= cbrs_pkg::REG_PERIOD;
    cfg_data   <= period;
    cfg_period  = period;
    @(negedge clk);
    cfg_index  <= cbrs_pkg::REG_LIMIT;
    cfg_data   <= {{(cbrs_pkg::CFG_W - cbrs_pkg::LIMIT_W){1'b0}}, limit};
    cfg_limit   = limit;
    @(negedge clk);
    cfg_write  <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed traffic on a running clock, with some noise beats
  function automatic cbrs_pkg::evt_t next_random_event(int unsigned step_max);
    cbrs_pkg::evt_t e;
    logic [63:0]    noise;
    int unsigned    pick;
    noise = {$urandom, $urandom};
    e = cbrs_pkg::evt_t'(noise[$bits(cbrs_pkg::evt_t)-1:0]);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      clock_ms = e.now_ms;
      return e;
    end
    clock_ms = clock_ms + $urandom_range(0, step_max);
    e.now_ms = clock_ms;
    if (sup_mode == cbrs_pkg::MODE_DISABLED && pick < 70) begin
      e.cmd        = cbrs_pkg::CMD_INSTALL;
      e.install_ok = (pick >= 12);
      return e;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      e.cmd       = cbrs_pkg::CMD_POLL;
      e.status_ok = ($urandom_range(0, 49) != 0);
      if ($urandom_range(0, 9) < 6) e.ctrl_state = cbrs_pkg::CTRL_RUNNING;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: e.tx_error_count = '0;
        4, 5, 6:    e.tx_error_count = 9'($urandom_range(0, 140));
        default:    e.tx_error_count = 9'($urandom_range(0, 511));
      endcase
      if ($urandom_range(0, 2) != 0) e.rx_error_count = 9'($urandom_range(0, 140));
    end else if (pick < 90) begin
      e.cmd = cbrs_pkg::CMD_TX;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: e.tx_outcome = cbrs_pkg::TX_TIMEOUT;
        5, 6, 7:       e.tx_outcome = cbrs_pkg::TX_SENT;
        default:       e.tx_outcome = 2'($urandom_range(0, 3));
      endcase
    end else if (pick < 96) begin
      e.cmd        = cbrs_pkg::CMD_INSTALL;
      e.install_ok = ($urandom_range(0, 9) != 0);
    end else begin
      e.cmd = cbrs_pkg::CMD_UNINSTALL;
    end
    return e;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned step_max);
    int unsigned done;
    done = 0;
    while (done < count) begin
      send_event(next_random_event(step_max));
      if (!last_was_noop) done++;
    end
    wait_for_results();
  endtask

  // reset register values: events while disabled, no auto recovery
  task automatic test_disabled_events();
    send_poll(32'd0, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd511, 9'd511);
    send_tx(cbrs_pkg::TX_TIMEOUT);
    send_install(1'b0);
    send_install(1'b1);
    send_poll(32'd50, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_uninstall();
    wait_for_results();
  endtask

  // probe, restart, stop, bus-off recovery and a zero timeout limit
  task automatic test_recovery_paths();
    set_registers(24'd10, 8'd0);
    send_install(1'b1);
    send_poll(32'd100, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_poll(32'd110, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_poll(32'd120, 1'b1, cbrs_pkg::CTRL_STOPPED, 9'd0, 9'd0);
    send_poll(32'd130, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd5, 9'd100);
    send_poll(32'd131, 1'b1, cbrs_pkg::CTRL_STOPPED, 9'd0, 9'd0);
    send_poll(32'd141, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd127);
    send_tx(cbrs_pkg::TX_TIMEOUT);
    send_tx(2'd3);
    send_poll(32'd150, 1'b1, cbrs_pkg::CTRL_STOPPED, 9'd0, 9'd0);
    send_poll(32'd151, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_poll(32'd161, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd200, 9'd0);
    send_poll(32'd170, 1'b1, cbrs_pkg::CTRL_BUSOFF, 9'd300, 9'd511);
    send_poll(32'd180, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd255, 9'd0);
    send_poll(32'd183, 1'b1, cbrs_pkg::CTRL_RECOVERING, 9'd96, 9'd0);
    send_poll(32'd185, 1'b0, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    wait_for_results();
  endtask

  // longest period, deadline that wraps past the top of the time range
  task automatic test_deadline_wrap();
    set_registers(24'hFFFFFF, 8'd255);
    send_install(1'b1);
    send_poll(32'hFFFF_FFF0, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_poll(32'hFFFF_FFFF, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    send_poll(32'h00FF_FFEF, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    wait_for_results();
  endtask

  // timeout count saturates while the result side holds off and fills up
  task automatic test_timeout_saturation();
    set_registers(24'd5, 8'd255);
    send_install(1'b1);
    send_poll(32'd1000, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    hold_cycles = 150;
    repeat (260) send_tx(cbrs_pkg::TX_TIMEOUT);
    send_poll(32'd1005, 1'b1, cbrs_pkg::CTRL_RUNNING, 9'd0, 9'd0);
    wait_for_results();
  endtask

  task automatic test_random_short_period();
    set_registers(24'd10, 8'd3);
    run_random(30, 6);
  endtask

  // no idling on either side for this stretch
  task automatic test_random_back_to_back();
    steady = 1'b1;
    set_registers(24'd1, 8'd1);
    run_random(30, 2);
    steady = 1'b0;
  endtask

  task automatic test_random_no_auto_recovery();
    set_registers(24'd0, 8'd255);
    run_random(15, 1000);
  endtask

  task automatic test_random_long_period();
    set_registers(24'hFFFFFF, 8'd16);
    clock_ms = 32'hFFF0_0000;
    run_random(20, 32'h3F_FFFF);
  endtask

  task automatic test_random_mixed();
    set_registers(24'd37, 8'd5);
    run_random(30, 25);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = cbrs_pkg::REG_PERIOD;
    cfg_data      = '0;
    evt_bus.valid = 1'b0;
    evt_bus.data  = '0;
    sup_mode      = cbrs_pkg::MODE_DISABLED;
    sup_deadline  = '0;
    sup_armed     = 1'b0;
    sup_timeouts  = '0;
    cfg_period    = cbrs_pkg::PERIOD_RESET;
    cfg_limit     = cbrs_pkg::LIMIT_RESET;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_disabled_events();
    test_recovery_paths();
    test_deadline_wrap();
    test_timeout_saturation();
    test_random_short_period();
    test_random_back_to_back();
    test_random_no_auto_recovery();
    test_random_long_period();
    test_random_mixed();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
design/cbrs_pkg.sv
design/cbrs_channels.sv
design/cbrs_step.sv
design/can_bus_off_recovery_supervisor.sv
design/cbrs_checker.sv
bench/tb.sv
